// File: hw/rtl/mixed_radix_digit_rotate_reorder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the digit rotate reorder block
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef MIXED_RADIX_DIGIT_ROTATE_REORDER_MACROS_SVH
`define MIXED_RADIX_DIGIT_ROTATE_REORDER_MACROS_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define MRDR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MRDR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MRDR_ASSERT(label, clk, rst_n, prop, msg)
`define MRDR_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: hw/rtl/mrdr_pkg.sv
// ----------------------------------------------------------------------------
// mrdr_pkg
// Types and codes shared by the digit rotate reorder modules.
// ----------------------------------------------------------------------------
package mrdr_pkg;

    localparam int ELEM_W_MAX = 64;
    localparam int RADIX_W    = 7;
    localparam int DIGITS_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_READY = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION    = 2'd2;

    typedef struct packed {
        logic                  op;
        logic [ELEM_W_MAX-1:0] element;
    } req_t;

    typedef struct packed {
        logic [ELEM_W_MAX-1:0] result_value;
        logic                  last_flag;
        logic                  status;
    } rsp_t;

    // geometry unit status toward the sequencer
    typedef struct packed {
        logic clear;  // register write this cycle, drop the current table
        logic done;   // sizes below are settled
        logic valid;  // geometry usable
    } geo_status_t;

endpackage

// File: hw/rtl/mrdr_ram.sv
// ----------------------------------------------------------------------------
// mrdr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mrdr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/mrdr_geom.sv
// ----------------------------------------------------------------------------
// mrdr_geom
// Configuration registers and the geometry unit: after reset or a register
// write it steps through the powers of the radix, one multiply per cycle,
// and captures the table size and the two address strides.
// ----------------------------------------------------------------------------
module mrdr_geom import mrdr_pkg::*; #(
    parameter int STORE_DEPTH = 4096,
    localparam int CW         = $clog2(STORE_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output geo_status_t           status,
    output logic [RADIX_W-1:0]    radix,
    output logic [CW-1:0]         total,
    output logic [CW-1:0]         low_span,
    output logic [CW-1:0]         y_stride
);

    localparam int PW = CW + RADIX_W;
    localparam logic [PW-1:0] DEPTH_WIDE = PW'(STORE_DEPTH);
    localparam logic [CW-1:0] SAT_VALUE  = CW'(STORE_DEPTH + 1);

    typedef enum logic [1:0] {
        GEO_RUN  = 2'b01,
        GEO_DONE = 2'b10
    } geo_state_t;

    geo_state_t           state_reg, state_next;
    logic [RADIX_W-1:0]   radix_reg, radix_next;
    logic [DIGITS_W-1:0]  digits_reg, digits_next;
    logic [DIGITS_W-1:0]  pos_reg, pos_next;
    logic [DIGITS_W-1:0]  k_reg, k_next;
    logic [CW-1:0]        pw_reg, pw_next;
    logic [CW-1:0]        total_reg, total_next;
    logic [CW-1:0]        low_reg, low_next;
    logic [CW-1:0]        ystr_reg, ystr_next;
    logic                 valid_reg, valid_next;

    logic                 cfg_hit;
    logic [DIGITS_W-1:0]  p_place;
    logic [DIGITS_W-1:0]  p_above;
    logic [PW-1:0]        prod;
    logic [CW-1:0]        pw_sat;

    assign p_place = digits_reg - DIGITS_W'(1) - pos_reg;
    assign p_above = p_place + DIGITS_W'(1);
    assign prod    = PW'(pw_reg) * PW'(radix_reg);
    assign pw_sat  = (prod > DEPTH_WIDE) ? SAT_VALUE : prod[CW-1:0];

    always_comb
    begin
        cfg_hit     = 1'b0;
        radix_next  = radix_reg;
        digits_next = digits_reg;
        pos_next    = pos_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RADIX:
                begin
                    radix_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                REG_DIGIT_COUNT:
                begin
                    digits_next = cfg_data[DIGITS_W-1:0];
                    cfg_hit     = 1'b1;
                end
                REG_POSITION:
                begin
                    pos_next = cfg_data[DIGITS_W-1:0];
                    cfg_hit  = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        pw_next    = pw_reg;
        total_next = total_reg;
        low_next   = low_reg;
        ystr_next  = ystr_reg;
        valid_next = valid_reg;
        unique case (state_reg)
            GEO_RUN:
            begin
                if (k_reg == p_place)
                begin
                    low_next = pw_reg;
                end
                if (k_reg == p_above)
                begin
                    ystr_next = pw_reg;
                end
                if (k_reg == digits_reg)
                begin
                    total_next = pw_reg;
                    valid_next = (radix_reg != '0) && (digits_reg != '0) &&
                                 (pos_reg < digits_reg) && (pw_reg <= CW'(STORE_DEPTH));
                    state_next = GEO_DONE;
                end
                else
                begin
                    pw_next = pw_sat;
                    k_next  = k_reg + DIGITS_W'(1);
                end
            end
            GEO_DONE:
            begin
                state_next = GEO_DONE;
            end
            default:
            begin
                state_next = GEO_RUN;
            end
        endcase
        // restart the power walk with the new register values
        if (cfg_hit)
        begin
            state_next = GEO_RUN;
            k_next     = '0;
            pw_next    = CW'(1);
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= GEO_RUN;
            radix_reg  <= RADIX_W'(2);
            digits_reg <= DIGITS_W'(1);
            pos_reg    <= '0;
            k_reg      <= '0;
            pw_reg     <= CW'(1);
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            radix_reg  <= radix_next;
            digits_reg <= digits_next;
            pos_reg    <= pos_next;
            k_reg      <= k_next;
            pw_reg     <= pw_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        low_reg   <= low_next;
        ystr_reg  <= ystr_next;
    end

    assign status.clear = cfg_hit;
    assign status.done  = (state_reg == GEO_DONE);
    assign status.valid = valid_reg;
    assign radix        = radix_reg;
    assign total        = total_reg;
    assign low_span     = low_reg;
    assign y_stride     = ystr_reg;

endmodule

// File: hw/rtl/mixed_radix_digit_rotate_reorder.sv
// ----------------------------------------------------------------------------
// mixed_radix_digit_rotate_reorder
// Loads a table in input order and returns it with one index digit rotated
// down to the least significant place and the digits below it moved up.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_t   (op, element)
//   rsp      out        rsp_valid / rsp_ready  rsp_t   (result_value, last_flag, status)
//   cfg      in         cfg_write              cfg_index, cfg_data
//
// One transaction per cycle on req while req_ready is high; each stored load is one
// RAM write, each ready fetch one RAM read. A fetch result passes the RAM read
// register, then the output register, before it shows on rsp.
// After reset and after each register write req_ready stays low while the
// geometry unit steps through the powers of the radix.
// With rsp_ready low the output register holds, one fetch waits in the read
// stage, and req_ready drops until the output drains.
// ----------------------------------------------------------------------------
module mixed_radix_digit_rotate_reorder import mrdr_pkg::*; #(
    parameter int STORE_DEPTH   = 4096,
    parameter int ELEMENT_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp
);

`include "mixed_radix_digit_rotate_reorder_macros.svh"

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int AW = $clog2(STORE_DEPTH);

    geo_status_t            geo_st;
    logic [RADIX_W-1:0]     geo_radix;
    logic [CW-1:0]          geo_total;
    logic [CW-1:0]          geo_low;
    logic [CW-1:0]          geo_ystr;

    logic [CW-1:0]          load_cnt_reg, load_cnt_next;
    logic [CW-1:0]          fetch_cnt_reg, fetch_cnt_next;
    logic [RADIX_W-1:0]     z_reg, z_next;
    logic [CW-1:0]          zoff_reg, zoff_next;
    logic [CW-1:0]          x_reg, x_next;
    logic [CW-1:0]          yoff_reg, yoff_next;

    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_ok_reg, s1_ok_next;
    logic                   s1_last_reg, s1_last_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    logic                   s1_move;
    logic                   accept;
    logic                   table_full;
    logic                   fetch_done;
    logic                   restart;
    logic                   load_go;
    logic                   fetch_ok;
    logic                   rd_en;
    logic                   last_hit;
    logic [CW-1:0]          addr_sum;
    logic [CW-1:0]          x_inc;
    logic [RADIX_W-1:0]     z_inc;
    logic [AW-1:0]          wr_addr;
    logic [ELEMENT_WIDTH-1:0] rd_data;

    mrdr_geom #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (geo_st),
        .radix     (geo_radix),
        .total     (geo_total),
        .low_span  (geo_low),
        .y_stride  (geo_ystr)
    );

    mrdr_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (load_go),
        .waddr (wr_addr),
        .wdata (req.element[ELEMENT_WIDTH-1:0]),
        .re    (rd_en),
        .raddr (addr_sum[AW-1:0]),
        .rdata (rd_data)
    );

    assign s1_move    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = geo_st.done && (!s1_valid_reg || s1_move);
    assign accept     = req_valid && req_ready;

    assign table_full = (load_cnt_reg >= geo_total);
    assign fetch_done = (fetch_cnt_reg >= geo_total);
    assign restart    = table_full;
    assign load_go    = accept && (req.op == OP_LOAD) && geo_st.valid &&
                        (!table_full || fetch_done);
    assign wr_addr    = restart ? '0 : load_cnt_reg[AW-1:0];

    assign fetch_ok   = geo_st.valid && table_full && !fetch_done;
    assign rd_en      = accept && (req.op == OP_FETCH) && fetch_ok;
    assign last_hit   = ((fetch_cnt_reg + CW'(1)) == geo_total);

    // output index walks z fastest, then x, then y
    assign addr_sum   = x_reg + yoff_reg + zoff_reg;
    assign z_inc      = z_reg + RADIX_W'(1);
    assign x_inc      = x_reg + CW'(1);

    always_comb
    begin
        load_cnt_next  = load_cnt_reg;
        fetch_cnt_next = fetch_cnt_reg;
        z_next         = z_reg;
        zoff_next      = zoff_reg;
        x_next         = x_reg;
        yoff_next      = yoff_reg;
        priority if (geo_st.clear)
        begin
            load_cnt_next  = '0;
            fetch_cnt_next = '0;
            z_next         = '0;
            zoff_next      = '0;
            x_next         = '0;
            yoff_next      = '0;
        end
        else if (load_go)
        begin
            if (restart)
            begin
                // new table: drop counters, element lands at index zero
                load_cnt_next  = CW'(1);
                fetch_cnt_next = '0;
                z_next         = '0;
                zoff_next      = '0;
                x_next         = '0;
                yoff_next      = '0;
            end
            else
            begin
                load_cnt_next = load_cnt_reg + CW'(1);
            end
        end
        else if (rd_en)
        begin
            fetch_cnt_next = fetch_cnt_reg + CW'(1);
            if (z_inc >= geo_radix)
            begin
                z_next    = '0;
                zoff_next = '0;
                if (x_inc >= geo_low)
                begin
                    x_next    = '0;
                    yoff_next = yoff_reg + geo_ystr;
                end
                else
                begin
                    x_next = x_inc;
                end
            end
            else
            begin
                z_next    = z_inc;
                zoff_next = zoff_reg + geo_low;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_ok_next    = s1_ok_reg;
        s1_last_next  = s1_last_reg;
        if (accept && (req.op == OP_FETCH))
        begin
            s1_valid_next = 1'b1;
            s1_ok_next    = fetch_ok;
            s1_last_next  = fetch_ok && last_hit;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (s1_move)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.result_value  = s1_ok_reg ? ELEM_W_MAX'(rd_data) : '0;
            rsp_next.last_flag     = s1_last_reg;
            rsp_next.status        = s1_ok_reg ? STATUS_OK : STATUS_NOT_READY;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg  <= '0;
            fetch_cnt_reg <= '0;
            z_reg         <= '0;
            zoff_reg      <= '0;
            x_reg         <= '0;
            yoff_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            load_cnt_reg  <= load_cnt_next;
            fetch_cnt_reg <= fetch_cnt_next;
            z_reg         <= z_next;
            zoff_reg      <= zoff_next;
            x_reg         <= x_next;
            yoff_reg      <= yoff_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg   <= s1_ok_next;
        s1_last_reg <= s1_last_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `MRDR_ASSERT_ALWAYS(a_no_accept_while_geo_busy, clk, !geo_st.done |-> !req_ready, "req accepted while geometry busy")
    `MRDR_ASSERT(a_read_needs_full_table, clk, rst_n, rd_en |-> (load_cnt_reg == geo_total), "read issued before load complete")
    `MRDR_ASSERT(a_read_addr_in_table, clk, rst_n, rd_en |-> (addr_sum < geo_total), "read address beyond table")
    `MRDR_ASSERT(a_clear_drops_counters, clk, rst_n, geo_st.clear |=> (load_cnt_reg == '0) && (fetch_cnt_reg == '0), "register write left counters")
    `MRDR_ASSERT(a_read_stage_holds, clk, rst_n, s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(s1_ok_reg), "stalled read stage lost")

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the digit rotate reorder block end to end. A short directed table
// covers reset state, field extremes, every kind of unusable geometry, full
// and refilled tables. Random phases follow: each one programs a geometry,
// then loads and fetches whole tables with random content, mixed with early
// fetches, dropped loads and fetches past the end. Every fetch result is
// compared field by field with a mirror of the table and digit counters.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mrdr_pkg::*;

    localparam int STORE_DEPTH   = 4096;
    localparam int ELEMENT_WIDTH = 64;
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_GAP       = 15;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 150;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 380;

    localparam logic [63:0] ALL_ONES = '1;
    localparam logic [63:0] ALT_A    = 64'h5555_5555_5555_5555;
    localparam logic [63:0] ALT_B    = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef struct {
        bit          usable;
        int unsigned total;
        int unsigned low_span;
        int unsigned y_stride;
    } geometry_t;

    typedef enum logic {ROW_SETUP, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [6:0]  radix_data;
        logic [6:0]  digits_data;
        logic [6:0]  pos_data;
        logic        op;
        logic [63:0] element;
        logic        pinned;
        rsp_t        pin;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req_payload;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp_payload;

    // expectation typed into the directed table, travels with the request
    logic                  pin_on;
    rsp_t                  pin_rsp;

    // mirror of the block state
    logic [63:0]           mirror_table [STORE_DEPTH];
    logic [6:0]            cur_radix  = 7'd2;
    logic [3:0]            cur_digits = 4'd1;
    logic [3:0]            cur_pos    = 4'd0;
    int unsigned           loads_done   = 0;
    int unsigned           fetches_done = 0;
    int unsigned           cnt_z = 0;
    int unsigned           cnt_x = 0;
    int unsigned           cnt_y = 0;
    rsp_t                  awaited [$];

    row_t                  directed [$];
    int unsigned           items_sent = 0;
    int unsigned           faults = 0;
    int unsigned           idle_cycles = 0;
    bit                    sender_quiet = 1'b0;
    bit                    receiver_quiet = 1'b0;
    bit                    long_hold_pending = 1'b0;
    bit                    hold_issued = 1'b0;

    mixed_radix_digit_rotate_reorder #(
        .STORE_DEPTH   (STORE_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_payload),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_payload)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic geometry_t geometry_of(logic [6:0] r, logic [3:0] d, logic [3:0] pos);
        geometry_t   g;
        int unsigned pw [0:15];
        int unsigned p;
        int unsigned k;
        g.usable   = 1'b0;
        g.total    = 0;
        g.low_span = 0;
        g.y_stride = 0;
        if (r == 0 || d == 0 || pos >= d)
            return g;
        pw[0] = 1;
        for (k = 1; k <= d; k++)
        begin
            // saturate just above the store size
            pw[k] = (pw[k-1] * r > STORE_DEPTH) ? STORE_DEPTH + 1 : pw[k-1] * r;
        end
        if (pw[d] > STORE_DEPTH)
            return g;
        p = d - 1 - pos;
        g.usable   = 1'b1;
        g.total    = pw[d];
        g.low_span = pw[p];
        g.y_stride = pw[p+1];
        return g;
    endfunction

    function void clear_progress();
        loads_done   = 0;
        fetches_done = 0;
        cnt_z = 0;
        cnt_x = 0;
        cnt_y = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_RADIX:       cur_radix  = data;
            REG_DIGIT_COUNT: cur_digits = data[3:0];
            REG_POSITION:    cur_pos    = data[3:0];
            default:         return;
        endcase
        clear_progress();
    endfunction

    function void predict_reorder(req_t t, logic pinned, rsp_t pin);
        geometry_t   g;
        rsp_t        r;
        int unsigned addr;
        g = geometry_of(cur_radix, cur_digits, cur_pos);
        if (t.op == OP_LOAD)
        begin
            if (!g.usable)
                return;
            if (loads_done >= g.total)
            begin
                // drop while the full table is still being fetched
                if (fetches_done < g.total)
                    return;
                clear_progress();
            end
            mirror_table[loads_done % STORE_DEPTH] = t.element;
            loads_done++;
            return;
        end
        r = '0;
        if (!g.usable || loads_done < g.total || fetches_done >= g.total)
            r.status = STATUS_NOT_READY;
        else
        begin
            addr = cnt_x + g.y_stride * cnt_y + g.low_span * cnt_z;
            r.result_value = mirror_table[addr % STORE_DEPTH];
            r.last_flag    = (fetches_done + 1 == g.total);
            r.status       = STATUS_OK;
            cnt_z++;
            if (cnt_z >= cur_radix)
            begin
                cnt_z = 0;
                cnt_x++;
                if (cnt_x >= g.low_span)
                begin
                    cnt_x = 0;
                    cnt_y++;
                end
            end
            fetches_done++;
        end
        awaited.push_back(pinned ? pin : r);
    endfunction

    function automatic row_t setup_row(logic [6:0] r, logic [6:0] d, logic [6:0] p);
        row_t w;
        w = '0;
        w.kind        = ROW_SETUP;
        w.radix_data  = r;
        w.digits_data = d;
        w.pos_data    = p;
        return w;
    endfunction

    function automatic row_t item_row(logic op, logic [63:0] element);
        row_t w;
        w = '0;
        w.kind    = ROW_ITEM;
        w.op      = op;
        w.element = element;
        return w;
    endfunction

    function automatic row_t pinned_fetch(logic [63:0] value, logic last, logic st);
        row_t w;
        w = item_row(OP_FETCH, ~value);
        w.pinned = 1'b1;
        w.pin    = {value, last, st};
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send(logic op, logic [63:0] element, logic pinned, rsp_t pin);
        int unsigned gap;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_payload <= {op, element};
        pin_on      <= pinned;
        pin_rsp     <= pin;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid, wait for every awaited result, then let a trailing load retire.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(logic [6:0] r, logic [6:0] d, logic [6:0] p);
        cfg_write <= 1'b1;
        cfg_index <= REG_RADIX;
        cfg_data  <= r;
        @(posedge clk);
        cfg_index <= REG_DIGIT_COUNT;
        cfg_data  <= d;
        @(posedge clk);
        cfg_index <= REG_POSITION;
        cfg_data  <= p;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic pick_geometry(output logic [6:0] r, output logic [6:0] d,
                                 output logic [6:0] p);
        int unsigned digits;
        int unsigned place;
        int unsigned span;
        digits = 1;
        place  = 0;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: r = 7'd0;
                    1:
                    begin
                        r      = 7'($urandom_range(1, 127));
                        digits = 0;
                        place  = $urandom_range(0, 15);
                    end
                    2:
                    begin
                        r      = 7'($urandom_range(1, 8));
                        digits = $urandom_range(1, 11);
                        place  = $urandom_range(digits, 15);
                    end
                    default:
                    begin
                        // table larger than the store
                        r      = 7'($urandom_range(65, 127));
                        digits = $urandom_range(2, 15);
                    end
                endcase
            end
            1: r = 7'($urandom_range(7, 64));
            2:
            begin
                r      = 7'd1;
                digits = $urandom_range(1, 12);
                place  = $urandom_range(0, digits - 1);
            end
            default:
            begin
                r    = 7'($urandom_range(2, 8));
                span = 32'(r);
                while (span * r <= 64)
                begin
                    span = span * r;
                    digits++;
                end
                digits = $urandom_range(1, digits);
                place  = $urandom_range(0, digits - 1);
            end
        endcase
        // upper data bits are masked off by the block
        d = {3'($urandom_range(0, 7)), 4'(digits)};
        p = {3'($urandom_range(0, 7)), 4'(place)};
    endtask

    task automatic run_table(int unsigned total, bit noisy);
        int unsigned n_load;
        bit          saved_quiet;
        n_load = (noisy && $urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
        for (int unsigned i = 0; i < n_load; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send(OP_FETCH, rand64(), 1'b0, '0);
            send(OP_LOAD, rand64(), 1'b0, '0);
        end
        if (n_load < total)
            return;
        if (noisy && $urandom_range(0, 3) == 0)
            send(OP_LOAD, rand64(), 1'b0, '0);
        saved_quiet = sender_quiet;
        if (!hold_issued && total >= 8)
        begin
            // stall the receiver once while fetches keep coming
            hold_issued       = 1'b1;
            long_hold_pending = 1'b1;
            sender_quiet      = 1'b1;
        end
        repeat (total) send(OP_FETCH, rand64(), 1'b0, '0);
        sender_quiet = saved_quiet;
        if (noisy && $urandom_range(0, 3) == 0)
            send(OP_FETCH, rand64(), 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cfg_write)
            apply_reg(cfg_index, cfg_data);
        else if (rst_n && req_valid && req_ready)
            predict_reorder(req_payload, pin_on, pin_rsp);
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited.size() == 0)
            begin
                $error("result with nothing awaited: %h", rsp_payload);
                faults++;
            end
            else
            begin
                want = awaited.pop_front();
                if (rsp_payload.result_value !== want.result_value)
                begin
                    $error("result_value: expected %h, got %h",
                           want.result_value, rsp_payload.result_value);
                    faults++;
                end
                if (rsp_payload.last_flag !== want.last_flag)
                begin
                    $error("last_flag: expected %b, got %b",
                           want.last_flag, rsp_payload.last_flag);
                    faults++;
                end
                if (rsp_payload.status !== want.status)
                begin
                    $error("status: expected %b, got %b", want.status, rsp_payload.status);
                    faults++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned pause;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            pause = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (pause != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        geometry_t   g;
        logic [6:0]  r;
        logic [6:0]  d;
        logic [6:0]  p;
        int unsigned n;
        int unsigned random_goal;

        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= REG_RADIX;
        cfg_data    <= '0;
        req_valid   <= 1'b0;
        req_payload <= '0;
        pin_on      <= 1'b0;
        pin_rsp     <= '0;

        directed = '{
            // reset geometry: radix 2, one digit
            pinned_fetch(64'h0, 1'b0, STATUS_NOT_READY),
            item_row(OP_LOAD, 64'h0),
            item_row(OP_LOAD, ALL_ONES),
            pinned_fetch(64'h0, 1'b0, STATUS_OK),
            pinned_fetch(ALL_ONES, 1'b1, STATUS_OK),
            pinned_fetch(64'h0, 1'b0, STATUS_NOT_READY),
            item_row(OP_LOAD, ALT_A),
            pinned_fetch(64'h0, 1'b0, STATUS_NOT_READY),
            // radix zero: loads dropped
            setup_row(7'd0, 7'd1, 7'd0),
            pinned_fetch(64'h0, 1'b0, STATUS_NOT_READY),
            item_row(OP_LOAD, 64'h0123_4567_89AB_CDEF),
            // position not below digit count
            setup_row(7'd127, 7'h7F, 7'h7F),
            pinned_fetch(64'h0, 1'b0, STATUS_NOT_READY),
            // table larger than the store
            setup_row(7'd2, 7'd13, 7'd0),
            pinned_fetch(64'h0, 1'b0, STATUS_NOT_READY),
            // radix one: single element table
            setup_row(7'd1, 7'd15, 7'd14),
            item_row(OP_LOAD, 64'hFEDC_BA98_7654_3210),
            pinned_fetch(64'hFEDC_BA98_7654_3210, 1'b1, STATUS_OK),
            // rotate the top digit down
            setup_row(7'd2, 7'd2, 7'd0),
            item_row(OP_LOAD, ALT_B),
            item_row(OP_LOAD, 64'h1),
            item_row(OP_LOAD, 64'h8000_0000_0000_0000),
            item_row(OP_LOAD, ALT_A),
            item_row(OP_LOAD, ALL_ONES),
            item_row(OP_FETCH, 64'h0),
            item_row(OP_FETCH, ALL_ONES),
            item_row(OP_FETCH, ALT_A),
            item_row(OP_FETCH, ALT_B),
            pinned_fetch(64'h0, 1'b0, STATUS_NOT_READY),
            item_row(OP_LOAD, 64'h2),
            // zero digits
            setup_row(7'd2, 7'd0, 7'd0),
            pinned_fetch(64'h0, 1'b0, STATUS_NOT_READY)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_SETUP)
            begin
                settle();
                program_regs(directed[i].radix_data, directed[i].digits_data,
                             directed[i].pos_data);
            end
            else
                send(directed[i].op, directed[i].element, directed[i].pinned,
                     directed[i].pin);
        end

        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal)
        begin
            pick_geometry(r, d, p);
            settle();
            program_regs(r, d, p);
            g = geometry_of(r, d[3:0], p[3:0]);
            sender_quiet   = ($urandom_range(0, 3) == 0);
            receiver_quiet = ($urandom_range(0, 3) == 0);
            if (!g.usable)
            begin
                n = $urandom_range(4, 10);
                repeat (n) send(1'($urandom_range(0, 1)), rand64(), 1'b0, '0);
            end
            else
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    if (items_sent < random_goal)
                        run_table(g.total, 1'b1);
                end
            end
        end

        // one table back to back, no idling on either side
        settle();
        program_regs(7'd4, 7'd3, 7'd1);
        g = geometry_of(7'd4, 4'd3, 4'd1);
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b1;
        run_table(g.total, 1'b0);

        settle();
        if (faults == 0 && awaited.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
